/* rtl/line_segment_window_clipper_defines.svh */
// Assertion macros shared by the checker.
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_DEFINES_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define LSWC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define LSWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lswc_pkg.sv */
`timescale 1ns / 1ps
package lswc_pkg;
  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  // Clip operations, one per cell, in order.
  typedef enum logic [2:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_BOTTOM = 3'd2,
    OP_TOP    = 3'd3
  } clip_op_t;
endpackage

/* rtl/lswc_div_cell.sv */
`timescale 1ns / 1ps
// One restoring-division step on a magnitude: shifts in one numerator bit.
module lswc_div_cell #(
  parameter int NW = 48,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW:0]   rem_in,
  input  logic [NW-1:0] num_in,
  input  logic [NW-1:0] quo_in,
  input  logic [DW-1:0] den,
  output logic [DW:0]   rem_out,
  output logic [NW-1:0] num_out,
  output logic [NW-1:0] quo_out
);
  logic [DW+1:0] trial;
  logic [DW:0]   shifted;

  always_comb begin
    shifted = {rem_in[DW-1:0], num_in[NW-1]};
    trial   = {1'b0, shifted} - {2'b0, den};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= {num_in[NW-2:0], 1'b0};
      if (!trial[DW+1]) begin
        rem_out <= trial[DW:0];
        quo_out <= {quo_in[NW-2:0], 1'b1};
      end else begin
        rem_out <= shifted;
        quo_out <= {quo_in[NW-2:0], 1'b0};
      end
    end
  end
endmodule

/* rtl/lswc_clip_cell.sv */
`timescale 1ns / 1ps
// One clip move: optionally moves one endpoint coordinate to a boundary and
// recomputes the other through a pipelined divider chain.
module lswc_clip_cell #(
  parameter int CW = 16,
  parameter lswc_pkg::clip_op_t OP = lswc_pkg::OP_LEFT,
  parameter bit SEL_END = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vin,
  input  logic signed [CW-1:0] bnd,
  input  logic signed [CW-1:0] ox1, oy1, ox2, oy2,
  input  logic signed [CW-1:0] x1_in, y1_in, x2_in, y2_in,
  input  logic                 rej_in,
  output logic                 vout,
  output logic signed [CW-1:0] ox1_o, oy1_o, ox2_o, oy2_o,
  output logic signed [CW-1:0] x1_o, y1_o, x2_o, y2_o,
  output logic                 rej_o
);
  import lswc_pkg::*;
  localparam int DW = CW + 1;
  localparam int NW = 2 * CW + 2;
  localparam int L  = NW + 2;
  localparam bit ISX = (OP == OP_LEFT) || (OP == OP_RIGHT);
  localparam bit LOW = (OP == OP_LEFT) || (OP == OP_BOTTOM);

  typedef struct packed {
    logic          v;
    logic          rej;
    logic          mv;
    logic          neg;
    logic [CW-1:0] ox1, oy1, ox2, oy2, x1, y1, x2, y2, bnd;
    logic [CW:0]   vbase;
  } carry_t;

  logic signed [CW-1:0] u, w;
  logic signed [CW:0]   d, num, den;
  logic                 mv;
  logic [DW-1:0]        dmag;
  logic [CW:0]          nmag;

  always_comb begin
    u = SEL_END ? (ISX ? x2_in : y2_in) : (ISX ? x1_in : y1_in);
    w = SEL_END ? (ISX ? y2_in : x2_in) : (ISX ? y1_in : x1_in);
    mv = LOW ? (u < bnd) : (u > bnd);
    d = {bnd[CW-1], bnd} - {u[CW-1], u};
    num = ISX ? ({oy2[CW-1], oy2} - {oy1[CW-1], oy1})
              : ({ox2[CW-1], ox2} - {ox1[CW-1], ox1});
    den = ISX ? ({ox2[CW-1], ox2} - {ox1[CW-1], ox1})
              : ({oy2[CW-1], oy2} - {oy1[CW-1], oy1});
    dmag = den[CW] ? DW'(-den) : DW'(den);
    nmag = num[CW] ? (CW+1)'(-num) : (CW+1)'(num);
  end

  // Stage 0: operand magnitudes and signs.
  carry_t        c0;
  logic [DW-1:0] den0;
  logic [CW:0]   dm0;
  logic          dneg0;
  logic [CW:0]   nmag_r;
  always_ff @(posedge clk) begin
    if (rst) c0.v <= 1'b0;
    else c0.v <= vin;
    c0.rej <= rej_in; c0.mv <= mv && !rej_in && (den != '0);
    c0.ox1 <= ox1; c0.oy1 <= oy1; c0.ox2 <= ox2; c0.oy2 <= oy2;
    c0.x1 <= x1_in; c0.y1 <= y1_in; c0.x2 <= x2_in; c0.y2 <= y2_in;
    c0.bnd <= bnd; c0.vbase <= {w[CW-1], w};
    dm0 <= d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
    dneg0 <= d[CW];
    c0.neg <= num[CW] ^ den[CW];
    den0 <= dmag;
    nmag_r <= nmag;
  end

  // Stage 1: multiply.
  carry_t        c1, c1_next;
  logic [NW-1:0] p1;
  logic [DW-1:0] den1;
  always_comb begin
    c1_next     = c0;
    c1_next.v   = c0.v && !rst;
    c1_next.neg = c0.neg ^ dneg0;
  end
  always_ff @(posedge clk) begin
    c1 <= c1_next;
    p1 <= NW'(dm0) * NW'(nmag_r);
    den1 <= den0;
  end

  // Divider chain, one quotient bit per cell.
  logic [DW:0]   rem [NW+1];
  logic [NW-1:0] nn  [NW+1];
  logic [NW-1:0] qq  [NW+1];
  logic [DW-1:0] dd  [NW+1];
  carry_t        cc  [NW+1];
  assign rem[0] = '0; assign nn[0] = p1; assign qq[0] = '0;
  assign dd[0] = den1; assign cc[0] = c1;
  for (genvar k = 0; k < NW; k++) begin : g_div
    carry_t cc_next;
    lswc_div_cell #(.NW(NW), .DW(DW)) u_div (
      .clk(clk), .en(1'b1), .rem_in(rem[k]), .num_in(nn[k]), .quo_in(qq[k]),
      .den(dd[k]), .rem_out(rem[k+1]), .num_out(nn[k+1]), .quo_out(qq[k+1])
    );
    always_comb begin
      cc_next   = cc[k];
      cc_next.v = cc[k].v && !rst;
    end
    always_ff @(posedge clk) begin
      dd[k+1] <= dd[k];
      cc[k+1] <= cc_next;
    end
  end

  // Final: apply signed quotient with saturation.
  carry_t               cf;
  logic signed [NW+1:0] sum;
  logic signed [CW-1:0] nv;
  logic signed [CW-1:0] x1_next, y1_next, x2_next, y2_next;
  localparam logic signed [NW+1:0] CMAX = ((NW+2)'(1) << (CW-1)) - 1;
  localparam logic signed [NW+1:0] CMIN = -((NW+2)'(1) << (CW-1));
  always_comb begin
    cf  = cc[NW];
    sum = (NW+2)'(signed'(cf.vbase))
        + (cf.neg ? -$signed({2'b0, qq[NW]}) : $signed({2'b0, qq[NW]}));
    if (sum > CMAX) nv = CW'(CMAX);
    else if (sum < CMIN) nv = CW'(CMIN);
    else nv = sum[CW-1:0];
    x1_next = cf.x1; y1_next = cf.y1; x2_next = cf.x2; y2_next = cf.y2;
    if (cf.mv) begin
      if (!SEL_END) begin
        if (ISX) begin x1_next = cf.bnd; y1_next = nv; end
        else begin y1_next = cf.bnd; x1_next = nv; end
      end else begin
        if (ISX) begin x2_next = cf.bnd; y2_next = nv; end
        else begin y2_next = cf.bnd; x2_next = nv; end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else vout <= cf.v;
    rej_o <= cf.rej;
    ox1_o <= cf.ox1; oy1_o <= cf.oy1; ox2_o <= cf.ox2; oy2_o <= cf.oy2;
    x1_o <= x1_next; y1_o <= y1_next; x2_o <= x2_next; y2_o <= y2_next;
  end
endmodule

/* rtl/line_segment_window_clipper.sv */
`timescale 1ns / 1ps
// A request passes the entry stage, eight clip cells and the output stage
// before the done strobe rises. Throughput: one request every cycle. busy
// is always low; the receiver cannot stall and is never waited on.
// Reset (rst, synchronous) clears the pipeline valids and restores the window
// to left 0, bottom 0, right 639, top 479.
module line_segment_window_clipper #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         done,
  output logic                         visible,
  output logic signed [COORD_BITS-1:0] clip_start_x,
  output logic signed [COORD_BITS-1:0] clip_start_y,
  output logic signed [COORD_BITS-1:0] clip_end_x,
  output logic signed [COORD_BITS-1:0] clip_end_y,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lswc_pkg::*;
  localparam int CW = COORD_BITS;

  // Window regs, read live. User changes config only while idle (unenforced).
  logic signed [CW-1:0] win_left, win_bottom, win_right, win_top;
  logic [1:0] ridx;
  assign ridx = paddr[3:2];
  assign pready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left <= '0; win_bottom <= '0;
      win_right <= CW'(639); win_top <= CW'(479);
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_LEFT:   win_left   <= pwdata[CW-1:0];
        REG_BOTTOM: win_bottom <= pwdata[CW-1:0];
        REG_RIGHT:  win_right  <= pwdata[CW-1:0];
        REG_TOP:    win_top    <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_LEFT:   prdata = 32'(signed'(win_left));
      REG_BOTTOM: prdata = 32'(signed'(win_bottom));
      REG_RIGHT:  prdata = 32'(signed'(win_right));
      REG_TOP:    prdata = 32'(signed'(win_top));
      default:    prdata = '0;
    endcase
  end

  // Entry stage: trivial-reject test on the edge as given.
  logic                 v [9];
  logic                 rj [9];
  logic signed [CW-1:0] ax1 [9], ay1 [9], ax2 [9], ay2 [9];
  logic signed [CW-1:0] px1 [9], py1 [9], px2 [9], py2 [9];

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= start;
    rj[0] <= (start_x < win_left && end_x < win_left) ||
             (start_x > win_right && end_x > win_right) ||
             (start_y < win_bottom && end_y < win_bottom) ||
             (start_y > win_top && end_y > win_top);
    ax1[0] <= start_x; ay1[0] <= start_y; ax2[0] <= end_x; ay2[0] <= end_y;
    px1[0] <= start_x; py1[0] <= start_y; px2[0] <= end_x; py2[0] <= end_y;
  end

  // Eight clip cells in the fixed order S/E left, right, bottom, top.
  localparam clip_op_t OPS [8] = '{OP_LEFT, OP_LEFT, OP_RIGHT, OP_RIGHT,
                                   OP_BOTTOM, OP_BOTTOM, OP_TOP, OP_TOP};
  for (genvar i = 0; i < 8; i++) begin : g_cell
    logic signed [CW-1:0] b;
    assign b = (OPS[i] == OP_LEFT) ? win_left : (OPS[i] == OP_RIGHT) ? win_right :
               (OPS[i] == OP_BOTTOM) ? win_bottom : win_top;
    lswc_clip_cell #(.CW(CW), .OP(OPS[i]), .SEL_END(1'(i % 2))) u_cell (
      .clk(clk), .rst(rst), .vin(v[i]), .bnd(b),
      .ox1(ax1[i]), .oy1(ay1[i]), .ox2(ax2[i]), .oy2(ay2[i]),
      .x1_in(px1[i]), .y1_in(py1[i]), .x2_in(px2[i]), .y2_in(py2[i]),
      .rej_in(rj[i]), .vout(v[i+1]),
      .ox1_o(ax1[i+1]), .oy1_o(ay1[i+1]), .ox2_o(ax2[i+1]), .oy2_o(ay2[i+1]),
      .x1_o(px1[i+1]), .y1_o(py1[i+1]), .x2_o(px2[i+1]), .y2_o(py2[i+1]),
      .rej_o(rj[i+1])
    );
  end

  // Output stage: final inside test and result strobe.
  logic vis;
  assign vis = !rj[8] &&
               px1[8] >= win_left && px1[8] <= win_right &&
               py1[8] >= win_bottom && py1[8] <= win_top &&
               px2[8] >= win_left && px2[8] <= win_right &&
               py2[8] >= win_bottom && py2[8] <= win_top;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v[8];
    visible      <= vis;
    clip_start_x <= vis ? px1[8] : '0;
    clip_start_y <= vis ? py1[8] : '0;
    clip_end_x   <= vis ? px2[8] : '0;
    clip_end_y   <= vis ? py2[8] : '0;
  end
endmodule

/* rtl/lswc_checker.sv */
`timescale 1ns / 1ps
`include "line_segment_window_clipper_defines.svh"
module lswc_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  busy,
  input logic                  done,
  input logic                  visible,
  input logic [COORD_BITS-1:0] clip_start_x,
  input logic [COORD_BITS-1:0] clip_end_y,
  input logic                  pready
);
  `LSWC_ASSERT_IMP(a_never_busy, 1'b1, !busy, "busy raised")
  `LSWC_ASSERT_IMP(a_hidden_zero, done && !visible, clip_start_x == '0 && clip_end_y == '0,
    "rejected request carries coordinates")
  `LSWC_ASSERT_NEXT(a_no_done_after_reset, $past(rst), !done || !$past(rst, 2),
    "result right after reset")
  `LSWC_ASSERT_IMP(a_ready, 1'b1, pready, "pready dropped")
endmodule

bind line_segment_window_clipper lswc_checker #(.COORD_BITS(COORD_BITS)) u_lswc_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .visible(visible),
  .clip_start_x(clip_start_x), .clip_end_y(clip_end_y), .pready(pready)
);
